// File: sv/binary_to_intel_hex_encoder_assert.svh
// ----------------------------------------------------------------------------
// Intel HEX encoder assertion macros
// Shorthand for clocked implication checks, disabled while reset is held.
// ----------------------------------------------------------------------------
`ifndef BINARY_TO_INTEL_HEX_ENCODER_ASSERT_SVH
`define BINARY_TO_INTEL_HEX_ENCODER_ASSERT_SVH

// Same-cycle implication.
`define BIHEX_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BIHEX_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/bihex_pkg.sv
// ----------------------------------------------------------------------------
// Intel HEX encoder package
// Shared types, codes and helper functions of the record encoder.
// ----------------------------------------------------------------------------
package bihex_pkg;

  localparam int RECORD_MAX_DEF = 32;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int LEN_W      = 7;

  localparam logic [7:0] TYPE_DATA   = 8'h00;
  localparam logic [7:0] TYPE_EOF    = 8'h01;
  localparam logic [7:0] MARKER_CODE = 8'h1A;

  localparam logic [5:0]  RECORD_BYTES_RST = 6'd32;
  localparam logic [6:0]  HEX_NUM_OFS      = 7'd48;
  localparam logic [6:0]  HEX_ALPHA_OFS    = 7'd55;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RECORD_BYTES = 3'd0,
    REG_LOAD_BASE    = 3'd1,
    REG_RUN_ADDRESS  = 3'd2,
    REG_TWOS_SUM     = 3'd3,
    REG_BYTE_SELECT  = 3'd4,
    REG_END_RECORD   = 3'd5,
    REG_SKIP_COUNT   = 3'd6
  } reg_idx_t;

  typedef enum logic [1:0] {
    SEL_ALL  = 2'd0,
    SEL_EVEN = 2'd1,
    SEL_ODD  = 2'd2
  } byte_sel_t;

  typedef enum logic [3:0] {
    SRC_COUNT,
    SRC_ADDR_HI,
    SRC_ADDR_LO,
    SRC_TYPE_DATA,
    SRC_DATA,
    SRC_CSUM,
    SRC_EOF_COUNT,
    SRC_RUN_HI,
    SRC_RUN_LO,
    SRC_TYPE_EOF,
    SRC_EOF_CSUM,
    SRC_MARK
  } src_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_COUNT,
    ST_ADDR_HI,
    ST_ADDR_LO,
    ST_TYPE,
    ST_DATA,
    ST_CSUM,
    ST_EOF_COUNT,
    ST_EOF_HI,
    ST_EOF_LO,
    ST_EOF_TYPE,
    ST_EOF_CSUM,
    ST_MARK
  } ctl_state_t;

  typedef struct packed {
    logic store;
    logic emit;
    src_t src;
    logic rec_start;
    logic rec_end;
    logic last;
    logic data_step;
    logic rec_done;
    logic rearm;
  } cmd_t;

  typedef struct packed {
    logic store_full;
    logic fill_nz;
    logic data_last;
    logic out_free;
    logic eor_en;
  } status_t;

  function automatic logic [6:0] hex_digit(input logic [3:0] nib);
    logic [6:0] ofs;
    ofs = (nib > 4'd9) ? HEX_ALPHA_OFS : HEX_NUM_OFS;
    return 7'(nib) + ofs;
  endfunction

  function automatic logic [7:0] finish_sum(input logic [7:0] sum, input logic twos);
    logic [7:0] inv;
    inv = ~sum;
    return twos ? (inv + 8'd1) : inv;
  endfunction

endpackage

// File: sv/bihex_ctrl.sv
// ----------------------------------------------------------------------------
// Intel HEX encoder controller
// Sequences the bytes of data records, the end record and the marker.
// ----------------------------------------------------------------------------
module bihex_ctrl
  import bihex_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  logic    in_op,
  input  status_t status,
  output cmd_t    cmd
);

  ctl_state_t state_r, state_nxt;
  logic       eos_r, eos_nxt;
  logic       accept;
  logic       fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      eos_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      eos_r   <= eos_nxt;
    end
  end

  always_comb begin
    in_ready      = (state_r == ST_IDLE);
    accept        = in_valid && in_ready;
    fire          = (state_r != ST_IDLE) && status.out_free;
    state_nxt     = state_r;
    eos_nxt       = eos_r;
    cmd           = '0;
    cmd.src       = SRC_COUNT;
    cmd.store     = accept && !in_op;
    cmd.emit      = (state_r != ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          eos_nxt = in_op;
          if (!in_op) begin
            if (status.store_full) begin
              state_nxt = ST_COUNT;
            end
          end else if (status.fill_nz) begin
            state_nxt = ST_COUNT;
          end else if (status.eor_en) begin
            state_nxt = ST_EOF_COUNT;
          end else begin
            state_nxt = ST_MARK;
          end
        end
      end
      ST_COUNT: begin
        cmd.src       = SRC_COUNT;
        cmd.rec_start = 1'b1;
        if (fire) state_nxt = ST_ADDR_HI;
      end
      ST_ADDR_HI: begin
        cmd.src = SRC_ADDR_HI;
        if (fire) state_nxt = ST_ADDR_LO;
      end
      ST_ADDR_LO: begin
        cmd.src = SRC_ADDR_LO;
        if (fire) state_nxt = ST_TYPE;
      end
      ST_TYPE: begin
        cmd.src = SRC_TYPE_DATA;
        if (fire) state_nxt = ST_DATA;
      end
      ST_DATA: begin
        cmd.src       = SRC_DATA;
        cmd.data_step = fire;
        if (fire && status.data_last) state_nxt = ST_CSUM;
      end
      ST_CSUM: begin
        cmd.src      = SRC_CSUM;
        cmd.rec_end  = 1'b1;
        cmd.last     = !eos_r;
        cmd.rec_done = fire;
        if (fire) begin
          if (!eos_r) begin
            state_nxt = ST_IDLE;
          end else if (status.eor_en) begin
            state_nxt = ST_EOF_COUNT;
          end else begin
            state_nxt = ST_MARK;
          end
        end
      end
      ST_EOF_COUNT: begin
        cmd.src       = SRC_EOF_COUNT;
        cmd.rec_start = 1'b1;
        if (fire) state_nxt = ST_EOF_HI;
      end
      ST_EOF_HI: begin
        cmd.src = SRC_RUN_HI;
        if (fire) state_nxt = ST_EOF_LO;
      end
      ST_EOF_LO: begin
        cmd.src = SRC_RUN_LO;
        if (fire) state_nxt = ST_EOF_TYPE;
      end
      ST_EOF_TYPE: begin
        cmd.src = SRC_TYPE_EOF;
        if (fire) state_nxt = ST_EOF_CSUM;
      end
      ST_EOF_CSUM: begin
        cmd.src     = SRC_EOF_CSUM;
        cmd.rec_end = 1'b1;
        if (fire) state_nxt = ST_MARK;
      end
      ST_MARK: begin
        cmd.src   = SRC_MARK;
        cmd.last  = 1'b1;
        cmd.rearm = fire;
        if (fire) begin
          state_nxt = ST_IDLE;
          eos_nxt   = 1'b0;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// File: sv/bihex_dp.sv
// ----------------------------------------------------------------------------
// Intel HEX encoder datapath
// Holds the registers, the record buffer, the stream counters and the
// output register, and forms each record byte with its hex digits.
// ----------------------------------------------------------------------------
module bihex_dp
  import bihex_pkg::*;
#(
  parameter int RECORD_MAX = RECORD_MAX_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [7:0]            in_data_byte,
  input  cmd_t                  cmd,
  output status_t               status,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_kind,
  output logic [7:0]            out_record_byte,
  output logic [6:0]            out_hex_high,
  output logic [6:0]            out_hex_low,
  output logic                  out_record_start,
  output logic                  out_record_end,
  output logic                  out_last
);

  localparam int FW = $clog2(RECORD_MAX + 1);
  localparam int AW = (RECORD_MAX > 1) ? $clog2(RECORD_MAX) : 1;

  logic [5:0]  rec_bytes_r;
  logic [15:0] load_base_r;
  logic [15:0] run_addr_r;
  logic        twos_r;
  logic [1:0]  byte_sel_r;
  logic        eor_en_r;
  logic [15:0] skip_count_r;

  logic [FW-1:0] fill_r, fill_nxt;
  logic [FW-1:0] idx_r, idx_nxt;
  logic [7:0]    sum_r, sum_nxt;
  logic [15:0]   addr_r, addr_nxt;
  logic          parity_r, parity_nxt;
  logic [15:0]   skip_r, skip_nxt;

  logic [7:0] mem [RECORD_MAX];
  logic [7:0] rd_data_r;
  logic       mem_we;

  logic             out_valid_r;
  logic             kind_r, start_r, end_r, last_r;
  logic [7:0]       byte_r;
  logic [6:0]       hex_hi_r, hex_lo_r;

  logic [LEN_W-1:0] eff_len;
  logic             keep;
  logic             skipping;
  logic             load;
  logic [7:0]       byte_val;
  logic [7:0]       data_sum;
  logic [7:0]       eof_sum;

  always_comb begin
    if (rec_bytes_r == 6'd0) begin
      eff_len = LEN_W'(1);
    end else if (LEN_W'(rec_bytes_r) > LEN_W'(RECORD_MAX)) begin
      eff_len = LEN_W'(RECORD_MAX);
    end else begin
      eff_len = LEN_W'(rec_bytes_r);
    end
    case (byte_sel_r)
      SEL_EVEN: keep = !parity_r;
      SEL_ODD:  keep = parity_r;
      default:  keep = 1'b1;
    endcase
    skipping = (skip_r != 16'd0);
    mem_we   = cmd.store && !skipping && keep;
  end

  always_comb begin
    status.out_free   = !out_valid_r || out_ready;
    load              = cmd.emit && status.out_free;
    status.store_full = !skipping && keep && ((LEN_W'(fill_r) + LEN_W'(1)) >= eff_len);
    status.fill_nz    = (fill_r != '0);
    status.data_last  = (FW'(idx_r + 1'b1) == fill_r);
    status.eor_en     = eor_en_r;
  end

  always_comb begin
    fill_nxt   = fill_r;
    idx_nxt    = idx_r;
    sum_nxt    = sum_r;
    addr_nxt   = addr_r;
    parity_nxt = parity_r;
    skip_nxt   = skip_r;
    if (cmd.store) begin
      if (skipping) begin
        skip_nxt = skip_r - 16'd1;
      end else begin
        parity_nxt = !parity_r;
        if (keep) begin
          fill_nxt = FW'(fill_r + 1'b1);
          sum_nxt  = sum_r + in_data_byte;
        end
      end
    end
    if (cmd.data_step) begin
      idx_nxt = FW'(idx_r + 1'b1);
    end
    if (cmd.rec_done) begin
      idx_nxt  = '0;
      fill_nxt = '0;
      sum_nxt  = 8'd0;
      addr_nxt = addr_r + 16'(fill_r);
    end
    if (cmd.rearm) begin
      idx_nxt    = '0;
      fill_nxt   = '0;
      sum_nxt    = 8'd0;
      addr_nxt   = load_base_r;
      parity_nxt = 1'b0;
      skip_nxt   = skip_count_r;
    end
    if (cfg_we && (cfg_index == REG_LOAD_BASE)) begin
      addr_nxt = cfg_data;
    end
    if (cfg_we && (cfg_index == REG_SKIP_COUNT)) begin
      skip_nxt = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_bytes_r  <= RECORD_BYTES_RST;
      load_base_r  <= 16'd0;
      run_addr_r   <= 16'd0;
      twos_r       <= 1'b1;
      byte_sel_r   <= SEL_ALL;
      eor_en_r     <= 1'b1;
      skip_count_r <= 16'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RECORD_BYTES: rec_bytes_r  <= cfg_data[5:0];
        REG_LOAD_BASE:    load_base_r  <= cfg_data;
        REG_RUN_ADDRESS:  run_addr_r   <= cfg_data;
        REG_TWOS_SUM:     twos_r       <= cfg_data[0];
        REG_BYTE_SELECT:  byte_sel_r   <= cfg_data[1:0];
        REG_END_RECORD:   eor_en_r     <= cfg_data[0];
        REG_SKIP_COUNT:   skip_count_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r   <= '0;
      idx_r    <= '0;
      sum_r    <= 8'd0;
      addr_r   <= 16'd0;
      parity_r <= 1'b0;
      skip_r   <= 16'd0;
    end else begin
      fill_r   <= fill_nxt;
      idx_r    <= idx_nxt;
      sum_r    <= sum_nxt;
      addr_r   <= addr_nxt;
      parity_r <= parity_nxt;
      skip_r   <= skip_nxt;
    end
  end

  // The read port follows the next index, so the data register always
  // holds the entry at the current index.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[fill_r[AW-1:0]] <= in_data_byte;
    end
    rd_data_r <= mem[idx_nxt[AW-1:0]];
  end

  always_comb begin
    data_sum = 8'(fill_r) + addr_r[15:8] + addr_r[7:0] + sum_r;
    eof_sum  = run_addr_r[15:8] + run_addr_r[7:0] + TYPE_EOF;
    unique case (cmd.src)
      SRC_COUNT:     byte_val = 8'(fill_r);
      SRC_ADDR_HI:   byte_val = addr_r[15:8];
      SRC_ADDR_LO:   byte_val = addr_r[7:0];
      SRC_TYPE_DATA: byte_val = TYPE_DATA;
      SRC_DATA:      byte_val = rd_data_r;
      SRC_CSUM:      byte_val = finish_sum(data_sum, twos_r);
      SRC_EOF_COUNT: byte_val = 8'd0;
      SRC_RUN_HI:    byte_val = run_addr_r[15:8];
      SRC_RUN_LO:    byte_val = run_addr_r[7:0];
      SRC_TYPE_EOF:  byte_val = TYPE_EOF;
      SRC_EOF_CSUM:  byte_val = finish_sum(eof_sum, twos_r);
      SRC_MARK:      byte_val = MARKER_CODE;
      default:       byte_val = 8'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r   <= (cmd.src == SRC_MARK);
      byte_r   <= byte_val;
      hex_hi_r <= hex_digit(byte_val[7:4]);
      hex_lo_r <= hex_digit(byte_val[3:0]);
      start_r  <= cmd.rec_start;
      end_r    <= cmd.rec_end;
      last_r   <= cmd.last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = kind_r;
  assign out_record_byte  = byte_r;
  assign out_hex_high     = hex_hi_r;
  assign out_hex_low      = hex_lo_r;
  assign out_record_start = start_r;
  assign out_record_end   = end_r;
  assign out_last         = last_r;

endmodule

// File: sv/binary_to_intel_hex_encoder.sv
// ----------------------------------------------------------------------------
// Binary to Intel HEX encoder
// A byte that completes no record leaves the input ready for the next byte.
// A full or flushed record of n bytes blocks the input for n + 5 output
// transfers. End of stream adds five transfers for the end record, when it
// is enabled, and one for the marker. Output stalls lengthen the time that
// the input is blocked. Synchronous reset restores register defaults and
// rearms the stream counters.
// ----------------------------------------------------------------------------
`include "binary_to_intel_hex_encoder_assert.svh"

module binary_to_intel_hex_encoder
  import bihex_pkg::*;
#(
  parameter int RECORD_MAX = RECORD_MAX_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_op,
  input  logic [7:0]            in_data_byte,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_kind,
  output logic [7:0]            out_record_byte,
  output logic [6:0]            out_hex_high,
  output logic [6:0]            out_hex_low,
  output logic                  out_record_start,
  output logic                  out_record_end,
  output logic                  out_last
);

  cmd_t    cmd;
  status_t status;

  bihex_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_op    (in_op),
    .status   (status),
    .cmd      (cmd)
  );

  bihex_dp #(
    .RECORD_MAX (RECORD_MAX)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_data_byte     (in_data_byte),
    .cmd              (cmd),
    .status           (status),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_record_byte  (out_record_byte),
    .out_hex_high     (out_hex_high),
    .out_hex_low      (out_hex_low),
    .out_record_start (out_record_start),
    .out_record_end   (out_record_end),
    .out_last         (out_last)
  );

  `BIHEX_ASSERT_NEXT(a_eos_busy, in_valid && in_ready && in_op, !in_ready, "end of stream did not start output")
  `BIHEX_ASSERT_IMP(a_marker_last, out_valid && out_kind, out_last && !out_record_start, "marker not final")
  `BIHEX_ASSERT_IMP(a_count_range, out_valid && out_record_start, out_record_byte <= 8'(RECORD_MAX), "record count too large")

endmodule

// File: tb/hex_record_monitor.sv
// ----------------------------------------------------------------------------
// Intel HEX record monitor
// Follows register writes and input transfers, predicts the record bytes that
// each transfer should produce, and compares every output transfer with the
// oldest prediction field by field. Failures are counted for the top level.
// ----------------------------------------------------------------------------
module hex_record_monitor
  import bihex_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic                  in_op,
  input  logic [7:0]            in_data_byte,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic                  out_kind,
  input  logic [7:0]            out_record_byte,
  input  logic [6:0]            out_hex_high,
  input  logic [6:0]            out_hex_low,
  input  logic                  out_record_start,
  input  logic                  out_record_end,
  input  logic                  out_last,
  output int                    mismatches,
  output int                    outstanding
);

  localparam logic OP_END      = 1'b1;
  localparam logic KIND_RECORD = 1'b0;
  localparam logic KIND_MARKER = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [7:0] value;
    logic [6:0] digit_hi;
    logic [6:0] digit_lo;
    logic       opens;
    logic       closes;
    logic       tail;
  } hex_byte_t;

  hex_byte_t   due_bytes[$];

  logic [5:0]  rec_len_cfg;
  logic [15:0] load_addr_cfg;
  logic [15:0] run_addr_cfg;
  logic        twos_cfg;
  logic [1:0]  select_cfg;
  logic        eof_en_cfg;
  logic [15:0] skip_cfg;

  logic [7:0]  held [RECORD_MAX_DEF];
  logic [5:0]  held_cnt;
  logic [7:0]  held_sum;
  logic [15:0] rec_addr;
  logic        odd_pos;
  logic [15:0] to_skip;

  function automatic logic [6:0] ascii_digit(logic [3:0] v);
    logic [7:0] c;
    c = (v < 4'd10) ? 8'h30 + {4'h0, v} : 8'h41 + {4'h0, v} - 8'd10;
    return c[6:0];
  endfunction

  function automatic logic [7:0] seal(logic [7:0] s);
    return twos_cfg ? 8'(8'd0 - s) : ~s;
  endfunction

  function automatic void put_byte(logic kind, logic [7:0] v, logic opens, logic closes);
    hex_byte_t r;
    r.kind     = kind;
    r.value    = v;
    r.digit_hi = ascii_digit(v[7:4]);
    r.digit_lo = ascii_digit(v[3:0]);
    r.opens    = opens;
    r.closes   = closes;
    r.tail     = 1'b0;
    due_bytes.push_back(r);
  endfunction

  function automatic void flush_record();
    logic [7:0] n;
    logic [7:0] s;
    int k;
    n = {2'b00, held_cnt};
    s = n + rec_addr[15:8] + rec_addr[7:0] + TYPE_DATA + held_sum;
    put_byte(KIND_RECORD, n, 1'b1, 1'b0);
    put_byte(KIND_RECORD, rec_addr[15:8], 1'b0, 1'b0);
    put_byte(KIND_RECORD, rec_addr[7:0], 1'b0, 1'b0);
    put_byte(KIND_RECORD, TYPE_DATA, 1'b0, 1'b0);
    for (k = 0; k < held_cnt; k++)
      put_byte(KIND_RECORD, held[k], 1'b0, 1'b0);
    put_byte(KIND_RECORD, seal(s), 1'b0, 1'b1);
    rec_addr = rec_addr + {10'd0, held_cnt};
    held_cnt = '0;
    held_sum = '0;
  endfunction

  function automatic void rearm();
    held_cnt = '0;
    held_sum = '0;
    rec_addr = load_addr_cfg;
    odd_pos  = 1'b0;
    to_skip  = skip_cfg;
  endfunction

  function automatic void apply_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    case (reg_idx_t'(idx))
      REG_RECORD_BYTES: rec_len_cfg = d[5:0];
      REG_LOAD_BASE: begin
        load_addr_cfg = d;
        rec_addr      = d;
      end
      REG_RUN_ADDRESS:  run_addr_cfg = d;
      REG_TWOS_SUM:     twos_cfg = d[0];
      REG_BYTE_SELECT:  select_cfg = d[1:0];
      REG_END_RECORD:   eof_en_cfg = d[0];
      REG_SKIP_COUNT: begin
        skip_cfg = d;
        to_skip  = d;
      end
      default: ;
    endcase
  endfunction

  function automatic void encode_input(logic op, logic [7:0] b);
    int         start_n;
    logic       keep;
    logic [5:0] lim;
    hex_byte_t  last_one;
    start_n = due_bytes.size();
    lim = (rec_len_cfg == 6'd0) ? 6'd1 :
          (rec_len_cfg > 6'(RECORD_MAX_DEF)) ? 6'(RECORD_MAX_DEF) : rec_len_cfg;
    if (op != OP_END) begin
      if (to_skip != 16'd0) begin
        to_skip = to_skip - 16'd1;
      end else begin
        case (select_cfg)
          SEL_EVEN: keep = !odd_pos;
          SEL_ODD:  keep = odd_pos;
          default:  keep = 1'b1;
        endcase
        odd_pos = !odd_pos;
        if (keep) begin
          if (held_cnt < 6'(RECORD_MAX_DEF)) begin
            held[held_cnt] = b;
            held_cnt = held_cnt + 6'd1;
            held_sum = held_sum + b;
          end
          if (held_cnt >= lim)
            flush_record();
        end
      end
    end else begin
      if (held_cnt != 6'd0)
        flush_record();
      if (eof_en_cfg) begin
        put_byte(KIND_RECORD, 8'h00, 1'b1, 1'b0);
        put_byte(KIND_RECORD, run_addr_cfg[15:8], 1'b0, 1'b0);
        put_byte(KIND_RECORD, run_addr_cfg[7:0], 1'b0, 1'b0);
        put_byte(KIND_RECORD, TYPE_EOF, 1'b0, 1'b0);
        put_byte(KIND_RECORD, seal(run_addr_cfg[15:8] + run_addr_cfg[7:0] + TYPE_EOF),
                 1'b0, 1'b1);
      end
      put_byte(KIND_MARKER, MARKER_CODE, 1'b0, 1'b0);
      rearm();
    end
    if (due_bytes.size() > start_n) begin
      last_one = due_bytes.pop_back();
      last_one.tail = 1'b1;
      due_bytes.push_back(last_one);
    end
  endfunction

  function automatic int field_check(string field, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %02h, got %02h", field, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    hex_byte_t want;
    if (!rst_n) begin
      rec_len_cfg   = RECORD_BYTES_RST;
      load_addr_cfg = '0;
      run_addr_cfg  = '0;
      twos_cfg      = 1'b1;
      select_cfg    = SEL_ALL;
      eof_en_cfg    = 1'b1;
      skip_cfg      = '0;
      rearm();
      due_bytes.delete();
      mismatches = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (due_bytes.size() == 0) begin
          $error("unexpected output transfer, record byte %02h", out_record_byte);
          mismatches++;
        end else begin
          want = due_bytes.pop_front();
          mismatches += field_check("kind", 8'(want.kind), 8'(out_kind))
                      + field_check("record_byte", want.value, out_record_byte)
                      + field_check("hex_high", 8'(want.digit_hi), 8'(out_hex_high))
                      + field_check("hex_low", 8'(want.digit_lo), 8'(out_hex_low))
                      + field_check("record_start", 8'(want.opens), 8'(out_record_start))
                      + field_check("record_end", 8'(want.closes), 8'(out_record_end))
                      + field_check("last", 8'(want.tail), 8'(out_last));
        end
      end
      if (cfg_we)
        apply_write(cfg_index, cfg_data);
      if (in_valid && in_ready)
        encode_input(in_op, in_data_byte);
    end
    outstanding <= due_bytes.size();
  end

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// Intel HEX encoder testbench
// Drives byte streams into the encoder under a range of register settings,
// first a directed set of corner cases and then random streams, most with
// random idling on both sides, and takes its verdict from the record monitor.
// ----------------------------------------------------------------------------
module tb;
  import bihex_pkg::*;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_END  = 1'b1;

  logic                  clk          = 1'b0;
  logic                  rst_n        = 1'b0;
  logic                  cfg_we       = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index    = '0;
  logic [CFG_DATA_W-1:0] cfg_data     = '0;
  logic                  in_valid     = 1'b0;
  logic                  in_op        = 1'b0;
  logic [7:0]            in_data_byte = '0;
  logic                  out_ready    = 1'b0;
  logic                  in_ready;
  logic                  out_valid;
  logic                  out_kind;
  logic [7:0]            out_record_byte;
  logic [6:0]            out_hex_high;
  logic [6:0]            out_hex_low;
  logic                  out_record_start;
  logic                  out_record_end;
  logic                  out_last;

  int mismatches;
  int outstanding;
  int sent_items = 0;
  bit tx_gaps    = 1'b1;
  bit rx_stalls  = 1'b1;
  bit long_hold  = 1'b0;

  binary_to_intel_hex_encoder u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_record_byte  (out_record_byte),
    .out_hex_high     (out_hex_high),
    .out_hex_low      (out_hex_low),
    .out_record_start (out_record_start),
    .out_record_end   (out_record_end),
    .out_last         (out_last)
  );

  hex_record_monitor u_monitor (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_record_byte  (out_record_byte),
    .out_hex_high     (out_hex_high),
    .out_hex_low      (out_hex_low),
    .out_record_start (out_record_start),
    .out_record_end   (out_record_end),
    .out_last         (out_last),
    .mismatches       (mismatches),
    .outstanding      (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // The receiver either stalls in short random bursts or, on request, holds
  // off for a long stretch so that the encoder backs up into its input.
  initial begin
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
        out_ready <= 1'b1;
        long_hold = 1'b0;
      end else if (rx_stalls && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_item(logic op, logic [7:0] b);
    if (tx_gaps && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_op        <= op;
    in_data_byte <= b;
    in_valid     <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sent_items++;
  endtask

  task automatic send_byte(logic [7:0] b);
    send_item(OP_BYTE, b);
  endtask

  task automatic end_stream();
    send_item(OP_END, 8'($urandom_range(0, 255)));
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [15:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] reg_value(reg_idx_t r);
    case (r)
      REG_RECORD_BYTES: begin
        case ($urandom_range(0, 4))
          0:       return 16'($urandom_range(0, 3));
          1:       return 16'd32;
          2:       return 16'($urandom_range(33, 63));
          default: return 16'($urandom_range(4, 31));
        endcase
      end
      REG_LOAD_BASE, REG_RUN_ADDRESS:
        return ($urandom_range(0, 3) == 0) ? 16'hFFFF - 16'($urandom_range(0, 48))
                                           : 16'($urandom);
      REG_TWOS_SUM, REG_END_RECORD:
        return 16'($urandom_range(0, 1));
      REG_BYTE_SELECT:
        return 16'($urandom_range(0, 3));
      REG_SKIP_COUNT:
        return ($urandom_range(0, 2) == 0) ? 16'($urandom_range(1, 6)) : 16'd0;
      default:
        return 16'd0;
    endcase
  endfunction

  task automatic randomise_settings();
    int i;
    for (i = REG_RECORD_BYTES; i <= REG_SKIP_COUNT; i++)
      write_reg(reg_idx_t'(i), reg_value(reg_idx_t'(i)));
  endtask

  task automatic random_stream();
    int len;
    int cut;
    int k;
    reg_idx_t r;
    len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 45);
    cut = ($urandom_range(0, 5) == 0) ? $urandom_range(0, len) : -1;
    for (k = 0; k < len; k++) begin
      if (k == cut && !long_hold) begin
        settle();
        r = reg_idx_t'($urandom_range(REG_RECORD_BYTES, REG_SKIP_COUNT));
        write_reg(r, reg_value(r));
      end
      send_byte(8'($urandom_range(0, 255)));
    end
    end_stream();
  endtask

  initial begin
    int p;
    int mark;
    int guard;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty stream, then a short flushed record, under the reset settings.
    end_stream();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h5A);
    end_stream();
    settle();

    // One-byte records from a zero length, address wrap, ones complement,
    // and no end record.
    write_reg(REG_RECORD_BYTES, 16'd0);
    write_reg(REG_LOAD_BASE, 16'hFFFF);
    write_reg(REG_RUN_ADDRESS, 16'hFFFF);
    write_reg(REG_TWOS_SUM, 16'd0);
    write_reg(REG_END_RECORD, 16'd0);
    send_byte(8'hA5);
    send_byte(8'h3C);
    end_stream();
    settle();

    // Oversized length, unused selector, leading bytes skipped, then the
    // length is lowered while bytes are held.
    write_reg(REG_RECORD_BYTES, 16'd63);
    write_reg(REG_BYTE_SELECT, 16'd3);
    write_reg(REG_TWOS_SUM, 16'd1);
    write_reg(REG_END_RECORD, 16'd1);
    write_reg(REG_LOAD_BASE, 16'h1234);
    write_reg(REG_SKIP_COUNT, 16'd2);
    repeat (4) send_byte(8'($urandom_range(0, 255)));
    settle();
    write_reg(REG_RECORD_BYTES, 16'd2);
    send_byte(8'($urandom_range(0, 255)));
    settle();

    // Address and skip reloaded in mid-stream.
    write_reg(REG_LOAD_BASE, 16'h8000);
    write_reg(REG_SKIP_COUNT, 16'd1);
    send_byte(8'h81);
    send_byte(8'h7E);
    end_stream();
    settle();

    write_reg(REG_SKIP_COUNT, 16'hFFFF);
    send_byte(8'h11);
    send_byte(8'hEE);
    end_stream();
    settle();

    write_reg(REG_SKIP_COUNT, 16'd0);
    write_reg(REG_BYTE_SELECT, 16'(SEL_EVEN));
    repeat (4) send_byte(8'($urandom_range(0, 255)));
    end_stream();
    settle();
    write_reg(REG_BYTE_SELECT, 16'(SEL_ODD));
    repeat (3) send_byte(8'($urandom_range(0, 255)));
    end_stream();
    settle();

    for (p = 0; p < 8; p++) begin
      tx_gaps   = (p != 7);
      rx_stalls = (p != 7);
      randomise_settings();
      if (p == 2) begin
        write_reg(REG_RECORD_BYTES, 16'd2);
        write_reg(REG_BYTE_SELECT, 16'(SEL_ALL));
        write_reg(REG_SKIP_COUNT, 16'd0);
        long_hold = 1'b1;
      end
      mark = sent_items;
      while (sent_items - mark < 45)
        random_stream();
      settle();
    end

    in_valid <= 1'b0;
    @(posedge clk);
    guard = 0;
    while (outstanding != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
